// ----- hw/rtl/chunked_image_receiver_unit_defines.svh -----
// Assertion macros used by the receiver's result queue RTL.
`ifndef CHUNKED_IMAGE_RECEIVER_UNIT_DEFINES_SVH
`define CHUNKED_IMAGE_RECEIVER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CIRX_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset.
`define CIRX_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CIRX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/cirx_pkg.sv -----
// Shared types, codes and functions of the chunked image receiver.
package cirx_pkg;

	localparam int STAGING_ADDR_BITS = 18;
	localparam logic [31:0] STAGING_SPAN = 32'(64'd1 << STAGING_ADDR_BITS);

	// result kinds
	localparam logic [1:0] KIND_WRITE    = 2'd0;
	localparam logic [1:0] KIND_ACK      = 2'd1;
	localparam logic [1:0] KIND_COMPLETE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_SIZE_ERR   = 2'd1;
	localparam logic [1:0] ST_CRC_ERR    = 2'd2;
	localparam logic [1:0] ST_NO_SESSION = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CMD_TYPE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHUNK      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ABORT      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STAGE_LIM  = 3'd4;
	localparam int CFG_DATA_BITS = 19;

	// result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_BITS = 2;
	localparam int RQ_CNT_BITS = 3;

	localparam int M_TDATA_BITS = 96;

	typedef struct packed {
		logic [7:0]  cmd_type;
		logic [7:0]  start_code;
		logic [7:0]  chunk_code;
		logic [7:0]  abort_code;
		logic [18:0] staging_limit;
	} cirx_cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] next_idx;
		logic [15:0] acked_count;
		logic [31:0] crc_value;
		logic [17:0] stage_addr;
		logic [7:0]  write_data;
		logic        last;
	} cirx_res_t;

	// push request from the core into the result queue
	typedef struct packed {
		logic a_valid;
		logic b_valid;
	} cirx_push_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/chunked_image_receiver_unit.sv -----
// A byte accepted into the input register is processed and queued once the result queue
// has room, and its first result can then transfer on the result stream.
// Throughput: one byte per cycle. A byte that yields a write and a reply needs two
// output transfers; the input stalls only while the 4-entry result queue holds more
// than two results, which only a stalled master side causes.
// Reset (arst_n low, asynchronous): session idle, counters zero, CRC all ones,
// codes back to 32/1/2/3, staging limit 262144, queue empty.
module chunked_image_receiver_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_wen,
	input  logic [cirx_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [cirx_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	// message byte stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] msg_byte
	input  logic                                s_tlast,   // msg_end
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] status, [17:2] next_idx, [33:18] acked_count, [65:34] crc_value,
	// [83:66] stage_addr, [91:84] write_data, [95:92] zero
	output logic [cirx_pkg::M_TDATA_BITS-1:0]   m_tdata,
	output logic [1:0]                          m_tuser,   // [1:0] result_kind
	output logic                                m_tlast    // last_of_run
);
	import cirx_pkg::*;

	cirx_cfg_t  cfg_q;

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       fire;
	logic       room;

	cirx_push_t push;
	cirx_res_t  res_a;
	cirx_res_t  res_b;
	cirx_res_t  out_res;

	// the registered byte is consumed once the queue can absorb both its results
	assign fire = valid_s1 && room;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cmd_type <= 8'd32;
			cfg_q.start_code <= 8'd1;
			cfg_q.chunk_code <= 8'd2;
			cfg_q.abort_code <= 8'd3;
			cfg_q.staging_limit <= 19'd262144;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_CMD_TYPE:  cfg_q.cmd_type <= cfg_wdata[7:0];
				CFG_START:     cfg_q.start_code <= cfg_wdata[7:0];
				CFG_CHUNK:     cfg_q.chunk_code <= cfg_wdata[7:0];
				CFG_ABORT:     cfg_q.abort_code <= cfg_wdata[7:0];
				CFG_STAGE_LIM: cfg_q.staging_limit <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload holds while the stage waits
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1 <= s_tlast;
		end
	end

	cirx_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.msg_byte (byte_s1),
		.msg_end  (end_s1),
		.cfg      (cfg_q),
		.push     (push),
		.res_a    (res_a),
		.res_b    (res_b)
	);

	cirx_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res_a     (res_a),
		.res_b     (res_b),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {4'd0, out_res.write_data, out_res.stage_addr, out_res.crc_value,
		out_res.acked_count, out_res.next_idx, out_res.status};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

// ----- hw/rtl/cirx_core.sv -----
// Message parser, session state and result generation for one byte.
module cirx_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            msg_byte,
	input  logic                  msg_end,
	input  cirx_pkg::cirx_cfg_t   cfg,
	output cirx_pkg::cirx_push_t  push,
	output cirx_pkg::cirx_res_t   res_a,
	output cirx_pkg::cirx_res_t   res_b
);
	import cirx_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_RECV  = 2'd1;
	localparam logic [1:0] PH_ERROR = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [1:0] MK_NONE  = 2'd0;
	localparam logic [1:0] MK_START = 2'd1;
	localparam logic [1:0] MK_CHUNK = 2'd2;
	localparam logic [1:0] MK_ABORT = 2'd3;

	logic [4:0]  pos_q;
	logic        cmd_match_q;
	logic [7:0]  subtype_q;
	logic [31:0] pend_size_q;
	logic [15:0] pend_chunks_q;
	logic [31:0] pend_crc_q;
	logic [15:0] seq_idx_q;
	logic [1:0]  phase_q;
	logic [18:0] image_size_q;
	logic [15:0] chunk_total_q;
	logic [31:0] exp_crc_q;
	logic [15:0] chunks_done_q;
	logic [19:0] bytes_done_q;
	logic [31:0] run_crc_q;

	logic [7:0]  sub_eff;
	logic [1:0]  mkind;
	logic        chunk_wr;
	logic        wr_ok;
	logic [31:0] crc_new;
	logic [19:0] bytes_new;
	logic [15:0] cd_inc;
	logic        start_ok;
	logic        reply_valid;
	cirx_res_t   reply;
	cirx_res_t   wres;

	// next session state
	logic [1:0]  phase_d;
	logic [18:0] image_size_d;
	logic [15:0] chunk_total_d;
	logic [31:0] exp_crc_d;
	logic [15:0] chunks_done_d;
	logic [19:0] bytes_done_d;
	logic [31:0] run_crc_d;

	assign sub_eff = (pos_q == 5'd1) ? msg_byte : subtype_q;

	always_comb begin
		mkind = MK_NONE;
		if (pos_q != 5'd0 && cmd_match_q) begin
			if (sub_eff == cfg.start_code)      mkind = MK_START;
			else if (sub_eff == cfg.chunk_code) mkind = MK_CHUNK;
			else if (sub_eff == cfg.abort_code) mkind = MK_ABORT;
		end
	end

	assign chunk_wr = (mkind == MK_CHUNK) && (pos_q >= 5'd4) && (phase_q == PH_RECV)
		&& (seq_idx_q == chunks_done_q);
	assign wr_ok = chunk_wr && (bytes_done_q < {1'b0, cfg.staging_limit})
		&& ({12'd0, bytes_done_q} < STAGING_SPAN);
	assign crc_new = chunk_wr ? crc32_byte(run_crc_q, msg_byte) : run_crc_q;
	assign bytes_new = (chunk_wr && bytes_done_q != 20'hFFFFF) ? bytes_done_q + 20'd1
		: bytes_done_q;
	assign cd_inc = chunks_done_q + 16'd1;
	assign start_ok = (pos_q >= 5'd17) && (pend_size_q != 32'd0)
		&& (pend_size_q <= {13'd0, cfg.staging_limit});

	always_comb begin
		wres = '0;
		wres.kind = KIND_WRITE;
		wres.stage_addr = bytes_done_q[17:0];
		wres.write_data = msg_byte;

		reply = '0;
		reply.last = 1'b1;
		reply_valid = 1'b0;

		phase_d = phase_q;
		image_size_d = image_size_q;
		chunk_total_d = chunk_total_q;
		exp_crc_d = exp_crc_q;
		chunks_done_d = chunks_done_q;
		bytes_done_d = bytes_new;
		run_crc_d = crc_new;

		if (msg_end) begin
			case (mkind)
				MK_START: begin
					reply_valid = 1'b1;
					reply.kind = KIND_ACK;
					if (!start_ok) begin
						reply.status = ST_SIZE_ERR;
					end else begin
						reply.status = ST_OK;
						phase_d = PH_RECV;
						image_size_d = pend_size_q[18:0];
						chunk_total_d = pend_chunks_q;
						exp_crc_d = pend_crc_q;
						chunks_done_d = '0;
						bytes_done_d = '0;
						run_crc_d = '1;
					end
				end
				MK_CHUNK: begin
					reply_valid = 1'b1;
					reply.kind = KIND_ACK;
					if (pos_q < 5'd4) begin
						reply.status = ST_SIZE_ERR;
						reply.next_idx = chunks_done_q;
						reply.acked_count = chunks_done_q;
					end else if (phase_q != PH_RECV) begin
						reply.status = ST_NO_SESSION;
					end else if (seq_idx_q < chunks_done_q) begin
						// duplicate: acknowledge again, nothing written
						reply.status = ST_OK;
						reply.next_idx = chunks_done_q;
						reply.acked_count = chunks_done_q;
					end else if (seq_idx_q != chunks_done_q) begin
						reply.status = ST_CRC_ERR;
						reply.next_idx = chunks_done_q;
						reply.acked_count = chunks_done_q;
					end else begin
						chunks_done_d = cd_inc;
						if (cd_inc >= chunk_total_q) begin
							reply.kind = KIND_COMPLETE;
							if (bytes_new != {1'b0, image_size_q}) begin
								reply.status = ST_SIZE_ERR;
								phase_d = PH_ERROR;
							end else if (~crc_new != exp_crc_q) begin
								reply.status = ST_CRC_ERR;
								reply.crc_value = ~crc_new;
								phase_d = PH_ERROR;
							end else begin
								reply.status = ST_OK;
								reply.crc_value = ~crc_new;
								phase_d = PH_DONE;
							end
						end else begin
							reply.status = ST_OK;
							reply.next_idx = cd_inc;
							reply.acked_count = cd_inc;
						end
					end
				end
				MK_ABORT: begin
					phase_d = PH_IDLE;
					image_size_d = '0;
					chunk_total_d = '0;
					exp_crc_d = '0;
					chunks_done_d = '0;
					bytes_done_d = '0;
					run_crc_d = '1;
				end
				default: begin
				end
			endcase
		end

		wres.last = !reply_valid;
	end

	// compact: the write, when present, always goes first
	assign push.a_valid = fire && (wr_ok || reply_valid);
	assign push.b_valid = fire && wr_ok && reply_valid;
	assign res_a = wr_ok ? wres : reply;
	assign res_b = reply;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cmd_match_q <= 1'b0;
			subtype_q <= '0;
			pend_size_q <= '0;
			pend_chunks_q <= '0;
			pend_crc_q <= '0;
			seq_idx_q <= '0;
			phase_q <= PH_IDLE;
			image_size_q <= '0;
			chunk_total_q <= '0;
			exp_crc_q <= '0;
			chunks_done_q <= '0;
			bytes_done_q <= '0;
			run_crc_q <= '1;
		end else if (fire) begin
			case (pos_q)
				5'd1: subtype_q <= msg_byte;
				5'd2: begin
					pend_size_q[7:0] <= msg_byte;
					seq_idx_q[7:0] <= msg_byte;
				end
				5'd3: begin
					pend_size_q[15:8] <= msg_byte;
					seq_idx_q[15:8] <= msg_byte;
				end
				5'd4: pend_size_q[23:16] <= msg_byte;
				5'd5: pend_size_q[31:24] <= msg_byte;
				5'd6: pend_chunks_q[7:0] <= msg_byte;
				5'd7: pend_chunks_q[15:8] <= msg_byte;
				5'd10: pend_crc_q[7:0] <= msg_byte;
				5'd11: pend_crc_q[15:8] <= msg_byte;
				5'd12: pend_crc_q[23:16] <= msg_byte;
				5'd13: pend_crc_q[31:24] <= msg_byte;
				default: begin
				end
			endcase

			if (msg_end) begin
				pos_q <= '0;
				cmd_match_q <= 1'b0;
			end else begin
				if (pos_q == 5'd0) cmd_match_q <= (msg_byte == cfg.cmd_type);
				if (pos_q != 5'd31) pos_q <= pos_q + 5'd1;
			end

			phase_q <= phase_d;
			image_size_q <= image_size_d;
			chunk_total_q <= chunk_total_d;
			exp_crc_q <= exp_crc_d;
			chunks_done_q <= chunks_done_d;
			bytes_done_q <= bytes_done_d;
			run_crc_q <= run_crc_d;
		end
	end

endmodule

// ----- hw/rtl/cirx_rq.sv -----
// Result queue: takes up to two results a cycle, hands out one per transfer.
module cirx_rq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cirx_pkg::cirx_push_t push,
	input  cirx_pkg::cirx_res_t  res_a,
	input  cirx_pkg::cirx_res_t  res_b,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cirx_pkg::cirx_res_t  out_res
);
	import cirx_pkg::*;

	`include "chunked_image_receiver_unit_defines.svh"

	cirx_res_t              mem_q [RQ_DEPTH];
	logic [RQ_PTR_BITS-1:0] wp_q;
	logic [RQ_PTR_BITS-1:0] rp_q;
	logic [RQ_CNT_BITS-1:0] cnt_q;
	logic [RQ_CNT_BITS-1:0] push_n;
	logic                   pop;

	assign push_n = RQ_CNT_BITS'(push.a_valid) + RQ_CNT_BITS'(push.b_valid);
	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_res = mem_q[rp_q];
	// two free slots needed: a byte may produce a write and a reply
	assign room = (cnt_q <= RQ_CNT_BITS'(RQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.a_valid) mem_q[wp_q] <= res_a;
		if (push.b_valid) mem_q[wp_q + RQ_PTR_BITS'(1)] <= res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + push_n[RQ_PTR_BITS-1:0];
			if (pop) rp_q <= rp_q + RQ_PTR_BITS'(1);
			cnt_q <= cnt_q + push_n - RQ_CNT_BITS'(pop);
		end
	end

	`CIRX_ASSERT_NEVER(a_rq_overflow, (cnt_q + push_n - RQ_CNT_BITS'(pop)) > RQ_CNT_BITS'(RQ_DEPTH), "result queue overflow")
	`CIRX_ASSERT_NEVER(a_rq_order, push.b_valid && !push.a_valid, "second result pushed without first")
	`CIRX_ASSERT_NEXT(a_rq_count, pop && !push.a_valid, cnt_q == $past(cnt_q) - RQ_CNT_BITS'(1), "queue count lost a pop")

endmodule
